// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the SVPWM duty block.
// Each macro expands to one labelled concurrent assertion on a given clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Delayed implication, disabled while reset is asserted.
`define ASSERT_DELAY5(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##5 (cons)) \
    else $error("assertion failed");

// Condition that must hold in the cycle after reset is sampled low.
`define ASSERT_AFTER_RESET(lbl, clk, rst_n, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/svpwm_pkg.sv =====
// Package for the SVPWM min-max duty block: widths, constants and shared types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package svpwm_pkg;

  localparam int VOLT_W  = 16;
  localparam int PHASE_W = 17;
  localparam int DUTY_W  = 14;
  localparam int RECIP_W = 30;
  localparam int CFG_AW  = 2;

  typedef logic signed [VOLT_W-1:0]  volt_t;
  typedef logic signed [PHASE_W-1:0] phase_t;
  typedef logic [DUTY_W-1:0]         duty_t;
  typedef logic [RECIP_W-1:0]        recip_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_RECIP_BUS = 2'd0,
    REG_MIN_DUTY  = 2'd1,
    REG_MAX_DUTY  = 2'd2
  } cfg_reg_t;

  // sqrt(3)/2 in Q1.15.
  localparam logic signed [15:0] CLARKE_K   = 16'sd28378;
  localparam logic signed [15:0] DUTY_SCALE = 16'sd10000;
  localparam logic signed [15:0] DUTY_MID   = 16'sd5000;

  localparam recip_t RECIP_RST    = 30'd349525;
  localparam duty_t  MIN_DUTY_RST = 14'd500;
  localparam duty_t  MAX_DUTY_RST = 14'd9500;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

`default_nettype wire

// ===== sv/svpwm_clarke.sv =====
// First pipeline stage: inverse Clarke transform of the alpha/beta pair.
// Depends on svpwm_pkg.
`default_nettype none

module svpwm_clarke (
  input  wire logic                clk,
  input  wire svpwm_pkg::pipe_en_t en,
  input  wire svpwm_pkg::volt_t    v_alpha,
  input  wire svpwm_pkg::volt_t    v_beta,
  output svpwm_pkg::phase_t        ph_a_r,
  output svpwm_pkg::phase_t        ph_b_r,
  output svpwm_pkg::phase_t        ph_c_r
);

  logic signed [31:0] alpha_term;
  logic signed [31:0] beta_term;
  logic signed [31:0] sum_b;
  logic signed [31:0] sum_c;
  svpwm_pkg::phase_t  ph_a_nxt;
  svpwm_pkg::phase_t  ph_b_nxt;
  svpwm_pkg::phase_t  ph_c_nxt;

  assign alpha_term = -$signed({{2{v_alpha[15]}}, v_alpha, 14'd0});
  assign beta_term  = 32'(v_beta) * 32'(svpwm_pkg::CLARKE_K);
  assign sum_b      = alpha_term + beta_term;
  assign sum_c      = alpha_term - beta_term;

  // Taking the upper bits is a floor division by 2^15.
  assign ph_a_nxt = 17'(v_alpha);
  assign ph_b_nxt = $signed(sum_b[31:15]);
  assign ph_c_nxt = $signed(sum_c[31:15]);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      ph_a_r <= ph_a_nxt;
      ph_b_r <= ph_b_nxt;
      ph_c_r <= ph_c_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/svpwm_offset.sv =====
// Second pipeline stage: min-max common-mode offset of the three phases.
// Depends on svpwm_pkg.
`default_nettype none

module svpwm_offset (
  input  wire logic                clk,
  input  wire svpwm_pkg::pipe_en_t en,
  input  wire svpwm_pkg::phase_t   ph_a,
  input  wire svpwm_pkg::phase_t   ph_b,
  input  wire svpwm_pkg::phase_t   ph_c,
  output svpwm_pkg::phase_t        ph_a_r,
  output svpwm_pkg::phase_t        ph_b_r,
  output svpwm_pkg::phase_t        ph_c_r,
  output svpwm_pkg::phase_t        offset_r
);

  svpwm_pkg::phase_t  mx;
  svpwm_pkg::phase_t  mn;
  logic signed [17:0] mid_sum;
  svpwm_pkg::phase_t  offset_nxt;

  always_comb begin
    mx = ph_a;
    mn = ph_a;
    if (ph_b > mx) mx = ph_b;
    if (ph_c > mx) mx = ph_c;
    if (ph_b < mn) mn = ph_b;
    if (ph_c < mn) mn = ph_c;
  end

  assign mid_sum    = 18'(mx) + 18'(mn);
  assign offset_nxt = $signed(mid_sum[17:1]);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      ph_a_r   <= ph_a;
      ph_b_r   <= ph_b;
      ph_c_r   <= ph_c;
      offset_r <= offset_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/svpwm_lane.sv =====
// Stages three to five for one phase: subtract offset, scale by 10000 and by the bus reciprocal, add 5000, clamp.
// Depends on svpwm_pkg.
`default_nettype none

module svpwm_lane (
  input  wire logic                clk,
  input  wire svpwm_pkg::pipe_en_t en,
  input  wire svpwm_pkg::phase_t   phase,
  input  wire svpwm_pkg::phase_t   offset,
  input  wire svpwm_pkg::recip_t   recip,
  input  wire svpwm_pkg::duty_t    min_duty,
  input  wire svpwm_pkg::duty_t    max_duty,
  output svpwm_pkg::duty_t         duty_r
);

  logic signed [17:0] diff;
  logic signed [31:0] scl_nxt;
  logic signed [31:0] scl_r;
  logic signed [61:0] prod_nxt;
  logic signed [61:0] prod_r;
  logic signed [32:0] raw;
  logic signed [32:0] hi;
  logic signed [32:0] lo;
  logic signed [32:0] clamped;
  svpwm_pkg::duty_t   duty_nxt;

  assign diff     = 18'(phase) - 18'(offset);
  assign scl_nxt  = 32'(diff) * 32'(svpwm_pkg::DUTY_SCALE);
  assign prod_nxt = 62'(scl_r) * $signed({32'd0, recip});

  // The upper bits give the arithmetic shift by 30, rounding towards minus infinity.
  assign raw = 33'($signed(prod_r[61:30])) + 33'(svpwm_pkg::DUTY_MID);
  assign hi  = $signed({19'd0, max_duty});
  assign lo  = $signed({19'd0, min_duty});

  always_comb begin
    clamped = raw;
    if (clamped > hi) clamped = hi;
    if (clamped < lo) clamped = lo;
    duty_nxt = clamped[13:0];
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      scl_r <= scl_nxt;
    end
    if (en.s4) begin
      prod_r <= prod_nxt;
    end
    if (en.s5) begin
      duty_r <= duty_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/svpwm_min_max_duty.sv =====
// An input transfer passes the Clarke, offset, scale, product and duty registers in turn.
// Throughput: one voltage pair per cycle; the five-stage pipeline only stalls when
// the output register holds a result that is not taken, and bubbles are squeezed out.
// Reset: synchronous, active low; clears all valid bits and loads the register defaults.
// Depends on svpwm_pkg, svpwm_clarke, svpwm_offset, svpwm_lane and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module svpwm_min_max_duty (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // v_alpha [15:0], v_beta [31:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // duty_a [13:0], duty_b [27:14], duty_c [41:28], zero
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [29:0] cfg_wdata
);

  localparam int STAGES = 5;

  svpwm_pkg::recip_t   recip_r;
  svpwm_pkg::duty_t    min_duty_r;
  svpwm_pkg::duty_t    max_duty_r;
  logic [STAGES-1:0]   vld_r;
  logic [STAGES-1:0]   vld_nxt;
  logic [STAGES-1:0]   adv;
  svpwm_pkg::pipe_en_t en;

  svpwm_pkg::phase_t   c_a;
  svpwm_pkg::phase_t   c_b;
  svpwm_pkg::phase_t   c_c;
  svpwm_pkg::phase_t   o_a;
  svpwm_pkg::phase_t   o_b;
  svpwm_pkg::phase_t   o_c;
  svpwm_pkg::phase_t   o_off;
  svpwm_pkg::duty_t    duty_a;
  svpwm_pkg::duty_t    duty_b;
  svpwm_pkg::duty_t    duty_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_r    <= svpwm_pkg::RECIP_RST;
      min_duty_r <= svpwm_pkg::MIN_DUTY_RST;
      max_duty_r <= svpwm_pkg::MAX_DUTY_RST;
    end else if (cfg_wr_en) begin
      case (svpwm_pkg::cfg_reg_t'(cfg_addr))
        svpwm_pkg::REG_RECIP_BUS: begin
          recip_r <= cfg_wdata;
        end
        svpwm_pkg::REG_MIN_DUTY: begin
          min_duty_r <= cfg_wdata[13:0];
        end
        svpwm_pkg::REG_MAX_DUTY: begin
          max_duty_r <= cfg_wdata[13:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A stage takes new data when it is empty or its successor moves on.
  always_comb begin
    adv[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt = vld_r;
    if (adv[0]) vld_nxt[0] = in_tvalid;
    for (int i = 1; i < STAGES; i++) begin
      if (adv[i]) vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign en.s1 = adv[0];
  assign en.s2 = adv[1];
  assign en.s3 = adv[2];
  assign en.s4 = adv[3];
  assign en.s5 = adv[4];

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = {6'd0, duty_c, duty_b, duty_a};

  svpwm_clarke u_clarke (
    .clk     (clk),
    .en      (en),
    .v_alpha ($signed(in_tdata[15:0])),
    .v_beta  ($signed(in_tdata[31:16])),
    .ph_a_r  (c_a),
    .ph_b_r  (c_b),
    .ph_c_r  (c_c)
  );

  svpwm_offset u_offset (
    .clk      (clk),
    .en       (en),
    .ph_a     (c_a),
    .ph_b     (c_b),
    .ph_c     (c_c),
    .ph_a_r   (o_a),
    .ph_b_r   (o_b),
    .ph_c_r   (o_c),
    .offset_r (o_off)
  );

  svpwm_lane u_lane_a (
    .clk      (clk),
    .en       (en),
    .phase    (o_a),
    .offset   (o_off),
    .recip    (recip_r),
    .min_duty (min_duty_r),
    .max_duty (max_duty_r),
    .duty_r   (duty_a)
  );

  svpwm_lane u_lane_b (
    .clk      (clk),
    .en       (en),
    .phase    (o_b),
    .offset   (o_off),
    .recip    (recip_r),
    .min_duty (min_duty_r),
    .max_duty (max_duty_r),
    .duty_r   (duty_b)
  );

  svpwm_lane u_lane_c (
    .clk      (clk),
    .en       (en),
    .phase    (o_c),
    .offset   (o_off),
    .recip    (recip_r),
    .min_duty (min_duty_r),
    .max_duty (max_duty_r),
    .duty_r   (duty_c)
  );

  `ASSERT_IMPL(a_ready_when_out_empty, clk, rst_n, !out_tvalid, in_tready)
  `ASSERT_DELAY5(a_latency_empty, clk, rst_n, in_tvalid && in_tready && (vld_r == '0), out_tvalid)
  `ASSERT_AFTER_RESET(a_reset_clears_valid, clk, rst_n, !out_tvalid)

endmodule

`default_nettype wire
